// ===== rtl/i2cm_pkg.sv =====
// i2cm_pkg: shared types and codes for the I2C master byte engine.
// No dependencies; imported by i2cm_cfg, i2cm_step and i2c_master_byte_engine.
package i2cm_pkg;

    // command codes
    localparam logic [2:0] CMD_START   = 3'd0;
    localparam logic [2:0] CMD_STOP    = 3'd1;
    localparam logic [2:0] CMD_WRITE   = 3'd2;
    localparam logic [2:0] CMD_READ    = 3'd3;
    localparam logic [2:0] CMD_RECOVER = 3'd4;

    // status / error codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NACK    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W           = 2;
    localparam logic [1:0] REG_HALF_PERIOD     = 2'd0;
    localparam logic [1:0] REG_STRETCH_TIMEOUT = 2'd1;

    localparam logic [15:0] HALF_PERIOD_RST     = 16'd500;
    localparam logic [23:0] STRETCH_TIMEOUT_RST = 24'd50000;

    localparam logic [3:0] DATA_BITS = 4'd8;
    localparam logic [3:0] LAST_BIT  = 4'd9;

    typedef enum logic [15:0] {
        PH_IDLE    = 16'h0001,
        PH_S_WAIT  = 16'h0002,
        PH_S_D1    = 16'h0004,
        PH_S_D2    = 16'h0008,
        PH_S_D3    = 16'h0010,
        PH_T_D1    = 16'h0020,
        PH_T_WAIT  = 16'h0040,
        PH_T_D2    = 16'h0080,
        PH_T_D3    = 16'h0100,
        PH_B_SETUP = 16'h0200,
        PH_B_WAIT  = 16'h0400,
        PH_B_HIGH  = 16'h0800,
        PH_B_LOW   = 16'h1000,
        PH_R_WAIT  = 16'h2000,
        PH_R_D1    = 16'h4000,
        PH_R_LOW   = 16'h8000
    } phase_t;

    typedef struct packed {
        logic       command_valid;
        logic [2:0] command;
        logic [7:0] write_data;
        logic       ack_after_read;
        logic       scl_level;
        logic       sda_level;
    } cmd_item_t;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       ready_res;
        logic       done_res;
        logic [7:0] read_data;
        logic [1:0] status;
    } res_item_t;

    typedef struct packed {
        logic [15:0] half_period;
        logic [23:0] stretch_timeout;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] half_counter;
        logic [23:0] stretch_counter;
        logic [3:0]  bit_index;
        logic [7:0]  shift_byte;
        logic [3:0]  pulse_count;
        logic        scl_drive;
        logic        sda_drive;
        logic [2:0]  work_cmd;
        logic [1:0]  work_err;
        logic        ack_drive;
        logic [7:0]  last_read;
        logic [1:0]  last_status;
    } state_t;

endpackage

// ===== rtl/i2cm_cfg.sv =====
// i2cm_cfg: half period and stretch timeout registers with their write port.
// Depends on i2cm_pkg.
module i2cm_cfg
    import i2cm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [23:0]          cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{half_period: HALF_PERIOD_RST, stretch_timeout: STRETCH_TIMEOUT_RST};
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HALF_PERIOD:     cfg_reg.half_period     <= cfg_data[15:0];
                REG_STRETCH_TIMEOUT: cfg_reg.stretch_timeout <= cfg_data;
                default:             ; // unmapped index, write dropped
            endcase
        end
    end

endmodule

// ===== rtl/i2cm_step.sv =====
// i2cm_step: next-state and result logic for one tick of the bus sequencer.
// Depends on i2cm_pkg; purely combinational.
module i2cm_step
    import i2cm_pkg::*;
#(
    parameter int unsigned RECOVERY_PULSES = 9
)
(
    input  state_t    st,
    input  cfg_t      cfg,
    input  cmd_item_t item,
    output state_t    st_next,
    output res_item_t res
);

    // SDA drive for the bit about to be set up (1 pulls low)
    function automatic logic bit_drive(input logic [2:0] cmd, input logic [3:0] bi,
                                       input logic [7:0] sb, input logic ack);
        logic d;
        d = 1'b0;
        if (cmd == CMD_WRITE)
        begin
            if (bi < DATA_BITS)
                d = ~sb[3'(3'd7 - bi[2:0])];
        end
        else if (bi >= DATA_BITS)
        begin
            d = ack;
        end
        return d;
    endfunction

    logic [15:0] limit;
    logic [15:0] hc_inc;
    logic        half_done;
    logic        timed_out;
    logic [3:0]  bi_inc;
    logic        done;
    state_t      n;

    assign limit     = (cfg.half_period == 16'd0) ? 16'd1 : cfg.half_period;
    assign hc_inc    = st.half_counter + 16'd1;
    assign half_done = hc_inc >= limit;
    assign timed_out = st.stretch_counter >= cfg.stretch_timeout;
    assign bi_inc    = st.bit_index + 4'd1;

    always_comb
    begin
        n    = st;
        done = 1'b0;

        case (st.phase)
            PH_IDLE:
            begin
                if (item.command_valid && (item.command inside {[CMD_START:CMD_RECOVER]}))
                begin
                    n.work_cmd = item.command;
                    n.work_err = ST_OK;
                    n.half_counter    = '0;
                    n.stretch_counter = '0;
                    case (item.command)
                        CMD_START:
                        begin
                            n.sda_drive = 1'b0;
                            n.scl_drive = 1'b0;
                            n.phase     = PH_S_WAIT;
                        end
                        CMD_STOP:
                        begin
                            n.sda_drive = 1'b1;
                            n.phase     = PH_T_D1;
                        end
                        CMD_WRITE, CMD_READ:
                        begin
                            n.shift_byte = (item.command == CMD_WRITE) ? item.write_data : 8'd0;
                            n.ack_drive  = item.ack_after_read;
                            n.bit_index  = 4'd0;
                            n.sda_drive  = bit_drive(item.command, 4'd0, n.shift_byte,
                                                     item.ack_after_read);
                            n.phase      = PH_B_SETUP;
                        end
                        default: // recovery
                        begin
                            n.sda_drive   = 1'b0;
                            n.scl_drive   = 1'b0;
                            n.pulse_count = 4'd0;
                            n.phase       = PH_R_WAIT;
                        end
                    endcase
                end
            end

            PH_S_WAIT, PH_T_WAIT, PH_B_WAIT, PH_R_WAIT:
            begin
                if (item.scl_level || timed_out)
                begin
                    // start and stop carry on past a timeout
                    if (!item.scl_level && (st.phase == PH_B_WAIT || st.phase == PH_R_WAIT))
                        n.work_err = ST_TIMEOUT;
                    n.half_counter    = '0;
                    n.stretch_counter = '0;
                    case (st.phase)
                        PH_S_WAIT: n.phase = PH_S_D1;
                        PH_T_WAIT: n.phase = PH_T_D2;
                        PH_B_WAIT: n.phase = PH_B_HIGH;
                        default:   n.phase = PH_R_D1;
                    endcase
                end
                else
                begin
                    n.stretch_counter = st.stretch_counter + 24'd1;
                end
            end

            PH_S_D1, PH_S_D2, PH_S_D3, PH_T_D1, PH_T_D2, PH_T_D3,
            PH_B_SETUP, PH_B_HIGH, PH_B_LOW, PH_R_D1, PH_R_LOW:
            begin
                if (!half_done)
                begin
                    n.half_counter = hc_inc;
                end
                else
                begin
                    n.half_counter    = '0;
                    n.stretch_counter = '0;
                    case (st.phase)
                        PH_S_D1:
                        begin
                            n.sda_drive = 1'b1;
                            n.phase     = PH_S_D2;
                        end
                        PH_S_D2:
                        begin
                            n.scl_drive = 1'b1;
                            n.phase     = PH_S_D3;
                        end
                        PH_S_D3:
                        begin
                            done    = 1'b1;
                            n.phase = PH_IDLE;
                        end
                        PH_T_D1:
                        begin
                            n.scl_drive = 1'b0;
                            n.phase     = PH_T_WAIT;
                        end
                        PH_T_D2:
                        begin
                            n.sda_drive = 1'b0;
                            n.phase     = PH_T_D3;
                        end
                        PH_T_D3:
                        begin
                            // recovery fails if either line is still held low
                            if (st.work_cmd == CMD_RECOVER && st.work_err == ST_OK &&
                                (!item.scl_level || !item.sda_level))
                                n.work_err = ST_TIMEOUT;
                            done    = 1'b1;
                            n.phase = PH_IDLE;
                        end
                        PH_B_SETUP:
                        begin
                            n.scl_drive = 1'b0;
                            n.phase     = PH_B_WAIT;
                        end
                        PH_B_HIGH:
                        begin
                            if (st.work_err == ST_TIMEOUT)
                            begin
                                done    = 1'b1;
                                n.phase = PH_IDLE;
                            end
                            else
                            begin
                                if (st.work_cmd == CMD_WRITE && st.bit_index >= DATA_BITS &&
                                    item.sda_level)
                                    n.work_err = ST_NACK;
                                if (st.work_cmd == CMD_READ && st.bit_index < DATA_BITS)
                                    n.shift_byte = {st.shift_byte[6:0], item.sda_level};
                                n.scl_drive = 1'b1;
                                n.phase     = PH_B_LOW;
                            end
                        end
                        PH_B_LOW:
                        begin
                            n.bit_index = bi_inc;
                            if (bi_inc >= LAST_BIT)
                            begin
                                if (st.work_cmd == CMD_READ)
                                    n.last_read = st.shift_byte;
                                done    = 1'b1;
                                n.phase = PH_IDLE;
                            end
                            else
                            begin
                                n.sda_drive = bit_drive(st.work_cmd, bi_inc, st.shift_byte,
                                                        st.ack_drive);
                                n.phase     = PH_B_SETUP;
                            end
                        end
                        PH_R_D1:
                        begin
                            if (st.work_err == ST_OK &&
                                st.pulse_count < 4'(RECOVERY_PULSES) && !item.sda_level)
                            begin
                                n.scl_drive   = 1'b1;
                                n.pulse_count = st.pulse_count + 4'd1;
                                n.phase       = PH_R_LOW;
                            end
                            else
                            begin
                                n.sda_drive = 1'b1;
                                n.phase     = PH_T_D1;
                            end
                        end
                        default: // PH_R_LOW
                        begin
                            n.scl_drive = 1'b0;
                            n.phase     = PH_R_WAIT;
                        end
                    endcase
                end
            end

            default:
            begin
                n.phase           = PH_IDLE;
                n.half_counter    = '0;
                n.stretch_counter = '0;
            end
        endcase

        if (done)
            n.last_status = n.work_err;
    end

    assign st_next          = n;
    assign res.scl_pull_low = n.scl_drive;
    assign res.sda_pull_low = n.sda_drive;
    assign res.ready_res    = (n.phase == PH_IDLE);
    assign res.done_res     = done;
    assign res.read_data    = n.last_read;
    assign res.status       = n.last_status;

endmodule

// ===== rtl/i2c_master_byte_engine.sv =====
// i2c_master_byte_engine: open-drain I2C master sequencer, one bus tick per item.
// Depends on i2cm_pkg, i2cm_cfg and i2cm_step.
//
//   port group   dir  handshake            payload
//   cmd_*        in   cmd_valid/cmd_stall  cmd_item   (cmd_item_t, one bus tick)
//   res_*        out  res_valid/res_stall  res_item   (res_item_t, drives + status)
//   cfg_*        in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Every item passes through the input register, then through the step logic
// into the result register. Sustained rate is one item per cycle while
// res_stall is low; the sequencer state register is the only loop.
// rst_n clears the sequencer to idle, both lines released, status ok, and
// loads the config defaults (half period 500, stretch timeout 50000).
// A stalled result holds the step stage; the input register then fills and
// cmd_stall rises. cfg_ready is always high.
module i2c_master_byte_engine
    import i2cm_pkg::*;
#(
    parameter int unsigned RECOVERY_PULSES = 9
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  cmd_item_t            cmd_item,

    output logic                 res_valid,
    input  logic                 res_stall,
    output res_item_t            res_item,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [23:0]          cfg_data
);

    cfg_t      cfg;
    state_t    state_reg;
    state_t    state_next;
    res_item_t step_res;

    logic      in_valid_reg;
    cmd_item_t in_item_reg;
    logic      out_valid_reg;
    res_item_t out_item_reg;
    logic      advance;

    i2cm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    i2cm_step #(
        .RECOVERY_PULSES (RECOVERY_PULSES)
    ) u_step (
        .st      (state_reg),
        .cfg     (cfg),
        .item    (in_item_reg),
        .st_next (state_next),
        .res     (step_res)
    );

    // step stage moves when it holds an item and the result slot frees up
    assign advance   = in_valid_reg && (!out_valid_reg || !res_stall);
    assign cmd_stall = in_valid_reg && !advance;
    assign res_valid = out_valid_reg;
    assign res_item  = out_item_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!cmd_stall)
            in_valid_reg <= cmd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
            in_item_reg <= cmd_item;
    end

    // sequencer state, updated once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: PH_IDLE, default: '0};
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!res_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= step_res;
    end

    // a finished command always leaves the engine idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.done_res |-> res_item.ready_res)
        else $error("done without ready");

    // input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> in_valid_reg && out_valid_reg && res_stall)
        else $error("input stalled without a held result");

    // sequencer must not move while the result is held
    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_stall |=> $stable(state_reg))
        else $error("state moved under output stall");

    // status never takes the unused code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_item.status == ST_OK || res_item.status == ST_NACK ||
                       res_item.status == ST_TIMEOUT))
        else $error("bad status code");

endmodule
